// File: hdl/ilst_pkg.sv
`timescale 1ns / 1ps
package ilst_pkg;

  localparam int CAPACITY = 1024;
  localparam int DATA_W   = 32;
  localparam int OP_W     = 3;
  localparam int POS_W    = 12;
  localparam int ST_W     = 2;
  localparam int LEN_W    = 11;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int GRP      = 32;
  localparam int GRP_W    = $clog2(GRP);
  localparam int NUM_GRP  = (CAPACITY + GRP - 1) / GRP;

  localparam logic [OP_W-1:0] OP_GET  = 3'd0;
  localparam logic [OP_W-1:0] OP_HEAD = 3'd1;
  localparam logic [OP_W-1:0] OP_TAIL = 3'd2;
  localparam logic [OP_W-1:0] OP_AT   = 3'd3;
  localparam logic [OP_W-1:0] OP_DEL  = 3'd4;

  localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic             shift_up;
    logic             shift_down;
    logic [CNT_W-1:0] at;
    logic [CNT_W-1:0] cnt;
  } cell_ctrl_t;

  function automatic logic [LEN_W-1:0] to_len(input logic [CNT_W-1:0] cnt);
    logic [CMP_W-1:0] wide;
    wide = CMP_W'(cnt);
    return wide[LEN_W-1:0];
  endfunction

endpackage

// File: hdl/ilst_if.sv
`timescale 1ns / 1ps
interface ilst_req_if
  import ilst_pkg::*;
  ();
  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         opcode;
  logic signed [POS_W-1:0] position;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output opcode, output position, output value, input ready);
  modport sink   (input valid, input opcode, input position, input value, output ready);
endinterface

interface ilst_rsp_if
  import ilst_pkg::*;
  ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] read_value;
  logic                     found;
  logic [ST_W-1:0]          status;
  logic [LEN_W-1:0]         length;

  modport source (output valid, output read_value, output found, output status,
                  output length, input ready);
  modport sink   (input valid, input read_value, input found, input status,
                  input length, output ready);
endinterface

// File: hdl/ilst_cell.sv
`timescale 1ns / 1ps
module ilst_cell
  import ilst_pkg::*;
(
  input  logic              clk,
  input  logic [CNT_W-1:0]  pos,
  input  cell_ctrl_t        ctrl,
  input  logic [DATA_W-1:0] value,
  input  logic [DATA_W-1:0] prev_data,
  input  logic [DATA_W-1:0] next_data,
  output logic [DATA_W-1:0] data
);

  logic [CNT_W:0] pos_inc;

  assign pos_inc = {1'b0, pos} + (CNT_W+1)'(1);

  always_ff @(posedge clk) begin
    if (ctrl.shift_up) begin
      if (pos == ctrl.at) begin
        data <= value;
      end else if (pos > ctrl.at && pos <= ctrl.cnt) begin
        data <= prev_data;
      end
    end else if (ctrl.shift_down) begin
      if (pos >= ctrl.at && pos_inc < {1'b0, ctrl.cnt}) begin
        data <= next_data;
      end
    end
  end

endmodule

// File: hdl/ilst_rd_tree.sv
`timescale 1ns / 1ps
module ilst_rd_tree
  import ilst_pkg::*;
(
  input  logic              clk,
  input  logic [DATA_W-1:0] cell_data [CAPACITY],
  input  logic [CMP_W-1:0]  idx,
  output logic [DATA_W-1:0] rd
);

  logic [DATA_W-1:0] pad   [NUM_GRP][GRP];
  logic [DATA_W-1:0] grp_d [NUM_GRP];
  logic [DATA_W-1:0] grp_q [NUM_GRP];
  logic [DATA_W-1:0] rd_d;

  for (genvar g = 0; g < NUM_GRP; g++) begin : g_grp
    for (genvar j = 0; j < GRP; j++) begin : g_ent
      if (g * GRP + j < CAPACITY) begin : g_real
        assign pad[g][j] = cell_data[g*GRP+j];
      end else begin : g_pad
        assign pad[g][j] = '0;
      end
    end
  end

  always_comb begin
    for (int g = 0; g < NUM_GRP; g++) begin
      grp_d[g] = '0;
      for (int j = 0; j < GRP; j++) begin
        if (idx[GRP_W-1:0] == GRP_W'(j)) begin
          grp_d[g] = pad[g][j];
        end
      end
    end
  end

  always_comb begin
    rd_d = '0;
    for (int g = 0; g < NUM_GRP; g++) begin
      if (idx[CMP_W-1:GRP_W] == (CMP_W-GRP_W)'(g)) begin
        rd_d = grp_q[g];
      end
    end
  end

  always_ff @(posedge clk) begin
    grp_q <= grp_d;
    rd    <= rd_d;
  end

endmodule

// File: hdl/indexed_list_engine_unit.sv
`timescale 1ns / 1ps
// Ordered list of up to CAPACITY signed 32-bit words held in a row of cells;
// insert and delete shift every affected cell by one place at once.
// One operation at a time: a word passes S_EXEC, then S_DONE, which loads its
// result once the output is free; a get that hits also passes S_READ in between
// (two registered mux stages pick the cell). A new word is taken the cycle after
// the result is loaded, even while that result still waits on the output side.
module indexed_list_engine_unit
  import ilst_pkg::*;
(
  input  logic clk,
  input  logic rst,
  ilst_req_if.sink   req,
  ilst_rsp_if.source rsp
);

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_READ, S_DONE} state_t;

  state_t            state;
  logic [OP_W-1:0]   op_q;
  logic [CMP_W-1:0]  idx_q;
  logic [DATA_W-1:0] val_q;
  logic [CNT_W-1:0]  cnt;
  logic [ST_W-1:0]   st_q;
  logic              found_q;
  logic              out_valid;
  logic [DATA_W-1:0] out_value;
  logic              out_found;
  logic [ST_W-1:0]   out_status;
  logic [LEN_W-1:0]  out_length;

  logic [CMP_W-1:0]  pos_raw;
  logic [CMP_W-1:0]  pos_sat;
  logic [CMP_W-1:0]  cnt_x;
  logic [CMP_W-1:0]  at_x;
  logic              is_ins;
  logic              hit;
  logic              ins_range;
  logic              ins_full;
  logic [ST_W-1:0]   st_d;
  cell_ctrl_t        ctrl;
  logic [DATA_W-1:0] cell_q [CAPACITY];
  logic [DATA_W-1:0] tree_rd;

  assign pos_raw = CMP_W'(req.position[POS_W-2:0]);
  assign pos_sat = req.position[POS_W-1] ? '0 :
                   (pos_raw > CMP_W'(CAPACITY)) ? CMP_W'(CAPACITY) : pos_raw;

  assign cnt_x     = CMP_W'(cnt);
  assign hit       = idx_q < cnt_x;
  assign ins_range = at_x > cnt_x;
  assign ins_full  = cnt_x >= CMP_W'(CAPACITY);
  assign is_ins    = (op_q == OP_HEAD) || (op_q == OP_TAIL) || (op_q == OP_AT);

  always_comb begin
    unique case (op_q)
      OP_HEAD: at_x = '0;
      OP_TAIL: at_x = cnt_x;
      default: at_x = idx_q;
    endcase
  end

  always_comb begin
    st_d = ST_DONE;
    unique case (op_q)
      OP_GET, OP_DEL: begin
        if (!hit) begin
          st_d = ST_RANGE;
        end
      end
      OP_HEAD, OP_TAIL, OP_AT: begin
        priority if (ins_range) begin
          st_d = ST_RANGE;
        end else if (ins_full) begin
          st_d = ST_FULL;
        end
      end
      default: st_d = ST_DONE;
    endcase
  end

  assign ctrl.shift_up   = (state == S_EXEC) && is_ins && !ins_range && !ins_full;
  assign ctrl.shift_down = (state == S_EXEC) && (op_q == OP_DEL) && hit;
  assign ctrl.at         = (op_q == OP_DEL) ? CNT_W'(idx_q) : CNT_W'(at_x);
  assign ctrl.cnt        = cnt;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] prev_d;
    logic [DATA_W-1:0] next_d;
    if (i == 0) begin : g_first
      assign prev_d = val_q;
    end else begin : g_mid_lo
      assign prev_d = cell_q[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign next_d = cell_q[i];
    end else begin : g_mid_hi
      assign next_d = cell_q[i+1];
    end
    ilst_cell u_cell (
      .clk       (clk),
      .pos       (CNT_W'(i)),
      .ctrl      (ctrl),
      .value     (val_q),
      .prev_data (prev_d),
      .next_data (next_d),
      .data      (cell_q[i])
    );
  end

  ilst_rd_tree u_rd_tree (
    .clk       (clk),
    .cell_data (cell_q),
    .idx       (idx_q),
    .rd        (tree_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && rsp.ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            op_q  <= req.opcode;
            idx_q <= pos_sat;
            val_q <= req.value;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          st_q    <= st_d;
          found_q <= (op_q == OP_GET) && hit;
          if (ctrl.shift_up) begin
            cnt <= cnt + CNT_W'(1);
          end else if (ctrl.shift_down) begin
            cnt <= cnt - CNT_W'(1);
          end
          state <= ((op_q == OP_GET) && hit) ? S_READ : S_DONE;
        end
        S_READ: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || rsp.ready) begin
            out_valid  <= 1'b1;
            out_value  <= found_q ? tree_rd : '0;
            out_found  <= found_q;
            out_status <= st_q;
            out_length <= to_len(cnt);
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign req.ready      = (state == S_IDLE) && !rst;
  assign rsp.valid      = out_valid;
  assign rsp.read_value = out_value;
  assign rsp.found      = out_found;
  assign rsp.status     = out_status;
  assign rsp.length     = out_length;

endmodule

// File: hdl/ilst_check.sv
`timescale 1ns / 1ps
module ilst_check
  import ilst_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_ready,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input logic [DATA_W-1:0] rsp_read_value,
  input logic              rsp_found,
  input logic [ST_W-1:0]   rsp_status,
  input logic [LEN_W-1:0]  rsp_length
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_value)
      && $stable(rsp_found) && $stable(rsp_status) && $stable(rsp_length))
    else $error("response word changed while stalled");

  a_found_done: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_found |-> rsp_status == ST_DONE)
    else $error("found with non-done status");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_found |-> rsp_read_value == '0)
    else $error("nonzero read value without hit");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("second word taken while busy");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid after reset");

endmodule

bind indexed_list_engine_unit ilst_check u_ilst_check (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req.valid),
  .req_ready      (req.ready),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .rsp_read_value (rsp.read_value),
  .rsp_found      (rsp.found),
  .rsp_status     (rsp.status),
  .rsp_length     (rsp.length)
);

// File: test/indexed_list_engine_unit_tb.sv
`timescale 1ns / 1ps
module indexed_list_engine_unit_tb;
  import ilst_pkg::*;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int SETTLE_WAIT  = 12;
  localparam int HOLD_CYCLES  = 300;
  localparam int REPORT_LIMIT = 100;

  localparam logic [OP_W-1:0] OP_UNUSED_FIRST = OP_DEL + 1'b1;
  localparam logic [OP_W-1:0] OP_UNUSED_LAST  = '1;

  typedef struct packed {
    logic signed [DATA_W-1:0] read_value;
    logic                     found;
    logic [ST_W-1:0]          status;
    logic [LEN_W-1:0]         length;
  } list_result_t;

  logic clk;
  logic rst;

  ilst_req_if req_if ();
  ilst_rsp_if rsp_if ();

  indexed_list_engine_unit DUT (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  logic signed [DATA_W-1:0] list_cells[$];
  list_result_t             results_due[$];
  int                       mismatches;
  int                       result_count;
  int                       cycle_count;
  int                       send_idle_pct;
  int                       recv_stall_pct;
  int                       hold_len;
  int                       hold_left;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // list predictor
  function automatic logic [ST_W-1:0] insert_cell(input int at, input logic signed [DATA_W-1:0] v);
    if (at > list_cells.size()) return ST_RANGE;
    if (list_cells.size() >= CAPACITY) return ST_FULL;
    list_cells.insert(at, v);
    return ST_DONE;
  endfunction

  function automatic list_result_t apply_list_op(input logic [OP_W-1:0] op,
                                                 input logic signed [POS_W-1:0] pos,
                                                 input logic signed [DATA_W-1:0] val);
    list_result_t res;
    int           idx;
    res = '0;
    idx = pos[POS_W-1] ? 0 : int'(pos);
    if (idx > CAPACITY) idx = CAPACITY;
    case (op)
      OP_GET: begin
        if (idx < list_cells.size()) begin
          res.read_value = list_cells[idx];
          res.found      = 1'b1;
        end else begin
          res.status = ST_RANGE;
        end
      end
      OP_HEAD: res.status = insert_cell(0, val);
      OP_TAIL: res.status = insert_cell(list_cells.size(), val);
      OP_AT:   res.status = insert_cell(idx, val);
      OP_DEL: begin
        if (idx < list_cells.size()) list_cells.delete(idx);
        else res.status = ST_RANGE;
      end
      default: ;
    endcase
    res.length = LEN_W'(list_cells.size());
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
    if (mismatches < REPORT_LIMIT)
      $display("MISMATCH %s: got %0h want %0h at result %0d t=%0t", what, got, want,
               result_count, $time);
    mismatches++;
  endtask

  // valid stays up after acceptance; the next send or an idle call replaces it
  task automatic send_word(input logic [OP_W-1:0] op, input logic signed [POS_W-1:0] pos,
                           input logic signed [DATA_W-1:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid    <= 1'b1;
    req_if.opcode   <= op;
    req_if.position <= pos;
    req_if.value    <= val;
    do @(posedge clk); while (!req_if.ready);
    results_due.push_back(apply_list_op(op, pos, val));
  endtask

  task automatic wait_results_drained();
    req_if.valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  function automatic logic signed [POS_W-1:0] pick_position(input bit for_insert);
    int len;
    int r;
    int p;
    len = list_cells.size();
    r   = $urandom_range(99);
    if (r < 10) return POS_W'($urandom_range(2047)) | {1'b1, {(POS_W-1){1'b0}}};
    if (r < 20) begin
      p = len + $urandom_range(3);
      return POS_W'((p > 2047) ? 2047 : p);
    end
    if (r < 28) return POS_W'($urandom_range(2047));
    if (for_insert) return POS_W'($urandom_range(len, 0));
    return POS_W'((len == 0) ? 0 : $urandom_range(len - 1, 0));
  endfunction

  task automatic run_mixed_ops(input int count);
    int              r;
    logic [OP_W-1:0] op;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < 28)      op = OP_GET;
      else if (r < 40) op = OP_HEAD;
      else if (r < 52) op = OP_TAIL;
      else if (r < 66) op = OP_AT;
      else if (r < 94) op = OP_DEL;
      else             op = OP_W'($urandom_range(OP_UNUSED_LAST, OP_UNUSED_FIRST));
      send_word(op, pick_position(op == OP_HEAD || op == OP_TAIL || op == OP_AT), $urandom);
    end
  endtask

  task automatic test_directed_edges();
    send_word(OP_GET, 0, 0);
    send_word(OP_DEL, 0, 0);
    send_word(OP_AT, 1, 32'sd77);
    send_word(OP_AT, -2048, 32'sh8000_0000);
    send_word(OP_TAIL, 0, 32'sh7FFF_FFFF);
    send_word(OP_HEAD, 2047, -1);
    send_word(OP_AT, 3, 0);
    send_word(OP_AT, 2047, 32'sd5);
    send_word(OP_AT, 1024, 32'sd6);
    send_word(OP_GET, -1, 0);
    send_word(OP_GET, 3, 0);
    send_word(OP_GET, 4, 0);
    send_word(OP_GET, 2047, 0);
    send_word(OP_DEL, 2047, 0);
    send_word(OP_DEL, -1, 0);
    send_word(OP_DEL, 2, 0);
    for (int op = OP_UNUSED_FIRST; op <= OP_UNUSED_LAST; op++)
      send_word(OP_W'(op), POS_W'($urandom), $urandom);
    send_word(OP_GET, 1, 0);
    send_word(OP_AT, 1, 32'sd12345);
    send_word(OP_GET, 1, 0);
  endtask

  task automatic test_idle_mixes();
    send_idle_pct = 0;  recv_stall_pct = 0;  run_mixed_ops(80);
    send_idle_pct = 75; recv_stall_pct = 0;  run_mixed_ops(80);
    send_idle_pct = 0;  recv_stall_pct = 75; run_mixed_ops(80);
    send_idle_pct = 8;  recv_stall_pct = 8;  run_mixed_ops(80);
  endtask

  task automatic test_output_hold_off();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_len       = HOLD_CYCLES;
    run_mixed_ops(30);
  endtask

  task automatic test_fill_to_capacity();
    int r;
    send_idle_pct  = 8;
    recv_stall_pct = 8;
    while (list_cells.size() < CAPACITY) begin
      r = $urandom_range(99);
      if (r < 30)      send_word(OP_HEAD, POS_W'($urandom), $urandom);
      else if (r < 60) send_word(OP_TAIL, POS_W'($urandom), $urandom);
      else if (r < 92) send_word(OP_AT, POS_W'($urandom_range(list_cells.size(), 0)), $urandom);
      else if (r < 97) send_word(OP_GET, pick_position(0), 0);
      else             send_word(OP_DEL, pick_position(0), 0);
    end
    // refused inserts, saturated index at the limit
    send_word(OP_HEAD, 0, $urandom);
    send_word(OP_TAIL, 0, $urandom);
    send_word(OP_AT, 0, $urandom);
    send_word(OP_AT, 1024, $urandom);
    send_word(OP_AT, 2047, $urandom);
    send_word(OP_GET, 1023, 0);
    send_word(OP_GET, 1024, 0);
    send_word(OP_DEL, 1024, 0);
    send_word(OP_DEL, 1023, 0);
    send_word(OP_AT, 2047, $urandom);
    send_word(OP_GET, 1023, 0);
    run_mixed_ops(16);
  endtask

  task automatic test_pause_until_drained();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_mixed_ops(20);
    wait_results_drained();
    run_mixed_ops(20);
  endtask

  // receiver side
  initial begin
    rsp_if.ready <= 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_len != 0) begin
        hold_left = hold_len;
        hold_len  = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    list_result_t want;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (results_due.size() == 0) begin
        report_mismatch("unexpected word", rsp_if.read_value, 0);
      end else begin
        want = results_due.pop_front();
        if (rsp_if.read_value !== want.read_value)
          report_mismatch("read_value", rsp_if.read_value, want.read_value);
        if (rsp_if.found !== want.found)
          report_mismatch("found", rsp_if.found, want.found);
        if (rsp_if.status !== want.status)
          report_mismatch("status", rsp_if.status, want.status);
        if (rsp_if.length !== want.length)
          report_mismatch("length", rsp_if.length, want.length);
      end
      result_count++;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    mismatches     = 0;
    result_count   = 0;
    cycle_count    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_len       = 0;
    rst             <= 1'b1;
    req_if.valid    <= 1'b0;
    req_if.opcode   <= OP_GET;
    req_if.position <= '0;
    req_if.value    <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_edges();
    test_idle_mixes();
    test_output_hold_off();
    test_fill_to_capacity();
    test_pause_until_drained();
    wait_results_drained();

    if (mismatches == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
